/* sv/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned MaxResults = 2;

  localparam logic [15:0] ReplChar    = 16'hFFFD;
  localparam logic [7:0]  ContLowDef  = 8'h80;
  localparam logic [7:0]  ContHighDef = 8'hBF;
  localparam logic [7:0]  LeadTwoMin  = 8'hC2;
  localparam logic [7:0]  LeadTwoMax  = 8'hDF;
  localparam logic [7:0]  LeadThrMin  = 8'hE0;
  localparam logic [7:0]  LeadThrMax  = 8'hEF;
  localparam logic [7:0]  LeadFouMin  = 8'hF0;
  localparam logic [7:0]  LeadFouMax  = 8'hF4;
  localparam logic [7:0]  LeadE0      = 8'hE0;
  localparam logic [7:0]  LeadED      = 8'hED;
  localparam logic [7:0]  LeadF0      = 8'hF0;
  localparam logic [7:0]  LeadF4      = 8'hF4;
  localparam logic [7:0]  LowAfterE0  = 8'hA0;
  localparam logic [7:0]  HighAfterED = 8'h9F;
  localparam logic [7:0]  LowAfterF0  = 8'h90;
  localparam logic [7:0]  HighAfterF4 = 8'h8F;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [15:0] SurrHiBase  = 16'hD800;
  localparam logic [15:0] SurrLoBase  = 16'hDC00;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_end;
    logic        string_end;
  } out_req_t;

  typedef struct packed {
    logic [1:0]          count;
    out_req_t [1:0]      unit;
  } step_res_t;

endpackage

`default_nettype wire

/* sv/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and single-pass decode of one UTF-8 byte into up to two
// UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode import u8u16_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire in_req_t   req_i,
  output step_res_t      res_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  hi_q, hi_d;

  logic [7:0]  b;
  logic        fin;
  logic        in_range;
  logic [1:0]  acc_pend;
  logic [20:0] acc_part;
  logic [19:0] supp;
  logic        do_lead;
  logic [1:0]  n;
  out_req_t    u0, u1;

  assign b        = req_i.byte_in;
  assign fin      = req_i.final_byte;
  assign in_range = (b >= lo_q) && (b <= hi_q);
  assign acc_pend = pend_q - 2'd1;
  assign acc_part = {part_q[14:0], b[5:0]};
  assign supp     = acc_part[19:0] - SuppBase[19:0];

  always_comb begin
    pend_d  = pend_q;
    part_d  = part_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    n       = 2'd0;
    u0      = '0;
    u1      = '0;
    do_lead = 1'b0;

    if (pend_q != 2'd0) begin
      if (in_range) begin
        pend_d = acc_pend;
        part_d = acc_part;
        lo_d   = ContLowDef;
        hi_d   = ContHighDef;
        if (acc_pend == 2'd0) begin
          part_d = '0;
          if (acc_part > 21'h00FFFF) begin
            u0.code_unit = SurrHiBase + {6'd0, supp[19:10]};
            u1.code_unit = SurrLoBase + {6'd0, supp[9:0]};
            n = 2'd2;
          end else begin
            u0.code_unit = acc_part[15:0];
            n = 2'd1;
          end
        end
      end else begin
        u0.code_unit = ReplChar;
        u0.replaced  = 1'b1;
        n       = 2'd1;
        do_lead = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      pend_d = 2'd0;
      part_d = '0;
      lo_d   = ContLowDef;
      hi_d   = ContHighDef;
      if (b[7] == 1'b0) begin
        if (n == 2'd0) u0.code_unit = {8'd0, b};
        else           u1.code_unit = {8'd0, b};
        n = n + 2'd1;
      end else if (b >= LeadTwoMin && b <= LeadTwoMax) begin
        pend_d = 2'd1;
        part_d = {16'd0, b[4:0]};
      end else if (b >= LeadThrMin && b <= LeadThrMax) begin
        pend_d = 2'd2;
        part_d = {17'd0, b[3:0]};
        if (b == LeadE0) lo_d = LowAfterE0;
        if (b == LeadED) hi_d = HighAfterED;
      end else if (b >= LeadFouMin && b <= LeadFouMax) begin
        pend_d = 2'd3;
        part_d = {18'd0, b[2:0]};
        if (b == LeadF0) lo_d = LowAfterF0;
        if (b == LeadF4) hi_d = HighAfterF4;
      end else begin
        if (n == 2'd0) begin
          u0.code_unit = ReplChar;
          u0.replaced  = 1'b1;
        end else begin
          u1.code_unit = ReplChar;
          u1.replaced  = 1'b1;
        end
        n = n + 2'd1;
      end
    end

    if (fin && pend_d != 2'd0) begin
      if (n == 2'd0) begin
        u0.code_unit = ReplChar;
        u0.replaced  = 1'b1;
        n = 2'd1;
      end else if (n == 2'd1) begin
        u1.code_unit = ReplChar;
        u1.replaced  = 1'b1;
        n = 2'd2;
      end
      pend_d = 2'd0;
      part_d = '0;
      lo_d   = ContLowDef;
      hi_d   = ContHighDef;
    end

    if (n == 2'd1) begin
      u0.run_end    = 1'b1;
      u0.string_end = fin;
    end else if (n == 2'd2) begin
      u1.run_end    = 1'b1;
      u1.string_end = fin;
    end
  end

  assign res_o.count   = n;
  assign res_o.unit[0] = u0;
  assign res_o.unit[1] = u1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
      lo_q   <= ContLowDef;
      hi_q   <= ContHighDef;
    end else if (advance_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

endmodule

`default_nettype wire

/* sv/u8u16_obuf.sv */
// ----------------------------------------------------------------------------
// u8u16_obuf
// Two-slot result register: holds the code units of one byte and presents
// them in order on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_obuf import u8u16_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire step_res_t res_i,
  output logic           load_ok_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_req_t       out_req_o
);

  logic [1:0] cnt_q, cnt_d;
  out_req_t   s0_q, s0_d;
  out_req_t   s1_q, s1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = s0_q;
  assign pop         = out_valid_o && out_ready_i;
  assign load_ok_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (load_i) begin
      cnt_d = res_i.count;
      s0_d  = res_i.unit[0];
      s1_d  = res_i.unit[1];
    end else if (pop) begin
      // advance the second unit
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

`default_nettype wire

/* sv/utf8_to_utf16_transcoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// UTF-8 to UTF-16 transcoder with U+FFFD replacement of ill-formed subparts.
//
// Input channel: one UTF-8 byte per request, final_byte set on the last byte
// of the string. Output channel: one UTF-16 code unit per request, with
// replaced, run_end (last unit of a byte) and string_end (last unit of the
// string) flags.
// A request is held in an input register, decoded in one pass and written to
// a two-slot result register, from which its code units are presented in
// order. Throughput is one byte per cycle while each byte gives at most one
// unit and the receiver is ready; a byte giving two units (surrogate pair,
// or a replacement followed by a new unit) holds the result register until
// its second unit is taken. Bytes that give no unit produce no output.
// Reset clears the pending sequence and empties both registers; the next byte is
// taken as a lead byte.
// When the receiver stalls, the result register holds its units and the
// input register takes one more byte, then in_ready_o falls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_req_t      out_req_o
);

  logic      in_valid_q;
  in_req_t   in_q;
  logic      load_ok;
  logic      advance;
  step_res_t res;

  assign advance    = in_valid_q && load_ok;
  assign in_ready_o = !in_valid_q || load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (in_q),
    .res_o     (res)
  );

  u8u16_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

/* tb/utf8_to_utf16_transcoder_core_tb.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core_tb
// Self-checking bench for the UTF-8 to UTF-16 transcoder. Byte requests come
// from a queue: first a short directed set (extreme bytes, narrowed lead
// bytes, rejected continuations, sequences cut short at the string end), then
// random strings of mostly well-formed code points with some broken ones.
// A local decoder predicts every code unit with its flags, and the monitor
// compares each unit taken from the block against the oldest prediction.
// Both sides insert random gaps; one long receiver stall fills the block.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core_tb import u8u16_pkg::*; ();

  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam int         RandomBytes = 1300;
  localparam int         LongHold    = 300;
  localparam int         StallLimit  = 2000;
  localparam int         DrainCycles = 8;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;

  in_req_t  pending_bytes[$];
  out_req_t step_units[$];
  out_req_t expected_units[$];

  logic [1:0]  seq_left = '0;
  logic [20:0] seq_acc  = '0;
  logic [7:0]  cont_lo  = ContLowDef;
  logic [7:0]  cont_hi  = ContHighDef;

  int   tx_gap      = 0;
  int   rx_gap      = 0;
  int   tx_gap_max  = 14;
  int   rx_gap_max  = 14;
  int   idle_cycles = 0;
  int   mismatches  = 0;
  int   rand_bytes  = 0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;

  utf8_to_utf16_transcoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void restart_sequence();
    seq_left = '0;
    seq_acc  = '0;
    cont_lo  = ContLowDef;
    cont_hi  = ContHighDef;
  endfunction

  function automatic void push_unit(logic [15:0] cu, logic repl);
    out_req_t u;
    u = '{code_unit: cu, replaced: repl, run_end: 1'b0, string_end: 1'b0};
    if (step_units.size() < MaxResults) step_units.push_back(u);
  endfunction

  function automatic void emit_scalar(logic [20:0] cp);
    logic [20:0] v;
    v = cp - SuppBase;
    if (cp < SuppBase) begin
      push_unit(cp[15:0], 1'b0);
    end else begin
      push_unit(SurrHiBase + 16'(v[19:10]), 1'b0);
      push_unit(SurrLoBase + 16'(v[9:0]), 1'b0);
    end
  endfunction

  function automatic void take_lead(logic [7:0] b);
    restart_sequence();
    if (b <= AsciiMax) begin
      emit_scalar(21'(b));
    end else if (b >= LeadTwoMin && b <= LeadTwoMax) begin
      seq_left = 2'd1;
      seq_acc  = 21'(b[4:0]);
    end else if (b >= LeadThrMin && b <= LeadThrMax) begin
      seq_left = 2'd2;
      seq_acc  = 21'(b[3:0]);
      if (b == LeadE0) cont_lo = LowAfterE0;
      if (b == LeadED) cont_hi = HighAfterED;
    end else if (b >= LeadFouMin && b <= LeadFouMax) begin
      seq_left = 2'd3;
      seq_acc  = 21'(b[2:0]);
      if (b == LeadF0) cont_lo = LowAfterF0;
      if (b == LeadF4) cont_hi = HighAfterF4;
    end else begin
      push_unit(ReplChar, 1'b1);
    end
  endfunction

  function automatic void decode_byte(in_req_t r);
    logic [20:0] cp;
    out_req_t    last;
    step_units.delete();
    if (seq_left != 0) begin
      if (r.byte_in >= cont_lo && r.byte_in <= cont_hi) begin
        seq_acc  = {seq_acc[14:0], r.byte_in[5:0]};
        seq_left = seq_left - 2'd1;
        cont_lo  = ContLowDef;
        cont_hi  = ContHighDef;
        if (seq_left == 0) begin
          cp = seq_acc;
          restart_sequence();
          emit_scalar(cp);
        end
      end else begin
        push_unit(ReplChar, 1'b1);
        take_lead(r.byte_in);
      end
    end else begin
      take_lead(r.byte_in);
    end
    if (r.final_byte && seq_left != 0) begin
      push_unit(ReplChar, 1'b1);
      restart_sequence();
    end
    if (step_units.size() != 0) begin
      last = step_units.pop_back();
      last.run_end    = 1'b1;
      last.string_end = r.final_byte;
      step_units.push_back(last);
    end
    foreach (step_units[i]) expected_units.push_back(step_units[i]);
  endfunction

  task automatic queue_seq(logic [31:0] bytes, int n, logic fin);
    in_req_t r;
    for (int i = n - 1; i >= 0; i--) begin
      r.byte_in    = bytes[8*i +: 8];
      r.final_byte = fin && (i == 0);
      pending_bytes.push_back(r);
    end
  endtask

  task automatic queue_random_string();
    in_req_t    str[$];
    in_req_t    r;
    logic [7:0] seq[$];
    logic [20:0] cp;
    int         len;
    repeat ($urandom_range(6, 1)) begin
      seq.delete();
      len = $urandom_range(4, 1);
      case (len)
        1: begin
          cp = 21'($urandom_range(127, 0));
          seq.push_back(cp[7:0]);
        end
        2: begin
          cp = 21'($urandom_range(21'h7FF, 21'h80));
          seq.push_back({3'b110, cp[10:6]});
        end
        3: begin
          cp = 21'($urandom_range(21'hFFFF, 21'h800));
          // keep clear of the surrogate range
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h1000;
          seq.push_back({4'b1110, cp[15:12]});
        end
        default: begin
          cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
          seq.push_back({5'b11110, cp[20:18]});
        end
      endcase
      for (int i = len - 2; i >= 0; i--) seq.push_back({2'b10, 6'(cp >> (6 * i))});
      case ($urandom_range(7, 0))
        0: seq[0] = 8'($urandom);
        1: if (seq.size() > 1) void'(seq.pop_back());
        2: seq[$urandom_range(seq.size() - 1, 0)] = 8'($urandom);
        default: ;
      endcase
      foreach (seq[i]) begin
        r.byte_in    = seq[i];
        r.final_byte = 1'b0;
        str.push_back(r);
      end
    end
    r = str.pop_back();
    r.final_byte = 1'b1;
    str.push_back(r);
    foreach (str[i]) pending_bytes.push_back(str[i]);
    rand_bytes += str.size();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_units.size() != 0);
  endtask

  // Driver: offer byte requests from the queue, with a random gap after each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_req_i);
        tx_gap = $urandom_range(tx_gap_max, 0);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_req_i   <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: take code units, check against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h", out_req_o.code_unit));
        end else begin
          automatic out_req_t want = expected_units.pop_front();
          if (out_req_o.code_unit !== want.code_unit)
            report_mismatch($sformatf("code_unit %h, want %h",
                                      out_req_o.code_unit, want.code_unit));
          if (out_req_o.replaced !== want.replaced)
            report_mismatch($sformatf("replaced %b, want %b on unit %h",
                                      out_req_o.replaced, want.replaced, want.code_unit));
          if (out_req_o.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b on unit %h",
                                      out_req_o.run_end, want.run_end, want.code_unit));
          if (out_req_o.string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, want %b on unit %h",
                                      out_req_o.string_end, want.string_end,
                                      want.code_unit));
        end
        rx_gap = $urandom_range(rx_gap_max, 0);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        rx_gap = LongHold;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("FAIL utf8_to_utf16_transcoder_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    queue_seq(32'h00, 1, 1'b1);
    queue_seq(32'hE0A080, 3, 1'b0);
    queue_seq(32'hEFBFBD, 3, 1'b0);
    queue_seq(32'h80FF, 2, 1'b0);
    queue_seq(32'hC1F5, 2, 1'b0);
    queue_seq(32'hE09F, 2, 1'b0);
    queue_seq(32'hEDA0, 2, 1'b0);
    queue_seq(32'hF08F, 2, 1'b0);
    queue_seq(32'hF490, 2, 1'b0);
    queue_seq(32'hC241, 2, 1'b0);
    queue_seq(32'hE1, 1, 1'b1);
    queue_seq(32'hE180, 2, 1'b1);
    queue_seq(32'hF48FBFBF, 4, 1'b1);
    wait_drained();

    while (rand_bytes < RandomBytes) begin
      if (rand_bytes >= 400 && rand_bytes < 700) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else if (rand_bytes >= 700 && !paused) begin
        // hold off the sender until every unit is out, then stall the receiver
        wait_drained();
        paused     = 1'b1;
        hold_req   = 1'b1;
        tx_gap_max = 0;
        rx_gap_max = 14;
      end else if (rand_bytes >= 1000) begin
        tx_gap_max = 14;
        rx_gap_max = 3;
      end
      while (pending_bytes.size() > 8) @(negedge clk_i);
      queue_random_string();
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS utf8_to_utf16_transcoder_core");
    end else begin
      $display("FAIL utf8_to_utf16_transcoder_core");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_obuf.sv
sv/utf8_to_utf16_transcoder_core.sv
tb/utf8_to_utf16_transcoder_core_tb.sv
